@@ rtl/atb_pkg.sv @@
`default_nettype none

package atb_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int IDX_W    = 10;
    localparam int WT_IN_W  = 32;
    localparam int WT_W     = 43;
    localparam int TOT_W    = 42;
    localparam int STS_W    = 2;
    localparam int CFG_W    = 11;

    // APB
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;
    localparam logic REG_ELEM_COUNT = 1'b0;
    localparam logic [CFG_W-1:0] ELEM_COUNT_RST = 11'd1024;

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 96;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_GET   = 2'd2;

    // Status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_PHASE = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SET_RD,
        ST_SET_WR,
        ST_GET_RD,
        ST_SCAN_RD,
        ST_SCAN_MUL,
        ST_SCAN_WR,
        ST_POP,
        ST_MV_RD,
        ST_MV_SUB,
        ST_MV_UPD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr;
        logic take_item;
        logic judge;
        logic set_rd;
        logic set_wr;
        logic get_rd;
        logic scan_init;
        logic scan_rd;
        logic scan_mul;
        logic scan_wr;
        logic pop;
        logic mv_rd;
        logic mv_sub;
        logic mv_upd;
        logic mark_built;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic             clear_done;
        logic [OP_W-1:0]  op;
        logic [STS_W-1:0] code;
        logic             cnt_zero;
        logic             scan_more;
        logic             can_move;
    } sts_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [TOT_W-1:0] threshold;
        logic [IDX_W-1:0] alias_index;
        logic [TOT_W-1:0] total;
    } res_t;

    function automatic logic [STS_W-1:0] req_status(
        input logic [OP_W-1:0] op,
        input logic            built,
        input logic            in_range
    );
        logic [STS_W-1:0] code;
        code = STS_PHASE;
        case (op)
            OP_SET: begin
                if (built)
                    code = STS_PHASE;
                else if (!in_range)
                    code = STS_RANGE;
                else
                    code = STS_OK;
            end
            OP_BUILD: begin
                code = built ? STS_PHASE : STS_OK;
            end
            OP_GET: begin
                if (!built)
                    code = STS_PHASE;
                else if (!in_range)
                    code = STS_RANGE;
                else
                    code = STS_OK;
            end
            default: begin
                code = STS_PHASE;
            end
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/atb_ctrl.sv @@
`default_nettype none

module atb_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         out_free,
    input  wire atb_pkg::sts_t st,
    output atb_pkg::cmd_t     cmd
);
    import atb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (st.clear_done) state_next = ST_IDLE;
            ST_IDLE:     if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (st.code != STS_OK)
                    state_next = ST_EMIT;
                else if (st.op == OP_SET)
                    state_next = ST_SET_RD;
                else if (st.op == OP_BUILD)
                    state_next = ST_SCAN_RD;
                else
                    state_next = ST_GET_RD;
            end
            ST_SET_RD:   state_next = ST_SET_WR;
            ST_SET_WR:   state_next = ST_EMIT;
            ST_GET_RD:   state_next = ST_EMIT;
            ST_SCAN_RD:  state_next = st.cnt_zero ? ST_POP : ST_SCAN_MUL;
            ST_SCAN_MUL: state_next = ST_SCAN_WR;
            ST_SCAN_WR:  state_next = st.scan_more ? ST_SCAN_MUL : ST_POP;
            ST_POP:      state_next = st.can_move ? ST_MV_RD : ST_EMIT;
            ST_MV_RD:    state_next = ST_MV_SUB;
            ST_MV_SUB:   state_next = ST_MV_UPD;
            ST_MV_UPD:   state_next = ST_POP;
            ST_EMIT:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:    cmd.clr = 1'b1;
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.take_item = s_tvalid;
            end
            ST_DECODE: begin
                cmd.judge     = 1'b1;
                cmd.scan_init = (st.code == STS_OK) && (st.op == OP_BUILD);
            end
            ST_SET_RD:   cmd.set_rd = 1'b1;
            ST_SET_WR:   cmd.set_wr = 1'b1;
            ST_GET_RD:   cmd.get_rd = 1'b1;
            ST_SCAN_RD:  cmd.scan_rd = !st.cnt_zero;
            ST_SCAN_MUL: cmd.scan_mul = 1'b1;
            ST_SCAN_WR:  cmd.scan_wr = 1'b1;
            ST_POP: begin
                cmd.pop        = st.can_move;
                cmd.mark_built = !st.can_move;
            end
            ST_MV_RD:    cmd.mv_rd = 1'b1;
            ST_MV_SUB:   cmd.mv_sub = 1'b1;
            ST_MV_UPD:   cmd.mv_upd = 1'b1;
            ST_EMIT:     cmd.emit = out_free;
            default:     cmd = '0;
        endcase
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result issued while output slot busy");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("clearing pass re-entered without reset");

    a_tready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("request taken outside idle");

endmodule

`default_nettype wire

@@ rtl/atb_dpath.sv @@
`default_nettype none

module atb_dpath #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire atb_pkg::cmd_t                 cmd,
    output atb_pkg::sts_t                      st,
    input  wire logic [atb_pkg::CFG_W-1:0]     element_count,
    input  wire logic [atb_pkg::OP_W-1:0]      in_op,
    input  wire logic [atb_pkg::IDX_W-1:0]     in_idx,
    input  wire logic [atb_pkg::WT_IN_W-1:0]   in_weight,
    output atb_pkg::res_t                      res
);
    import atb_pkg::*;

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam int PW   = WT_IN_W + CW;

    // Storage
    logic [WT_W-1:0] ws_mem  [MAX_ENTRIES];
    logic [AW-1:0]   al_mem  [MAX_ENTRIES];
    logic [AW-1:0]   ovs_mem [MAX_ENTRIES];
    logic [AW-1:0]   uns_mem [MAX_ENTRIES];

    // Control state
    logic [TOT_W-1:0] total_reg, total_next;
    logic             built_reg, built_next;
    logic [CW-1:0]    oc_reg, oc_next;
    logic [CW-1:0]    uc_reg, uc_next;
    logic [CW-1:0]    ptr_reg, ptr_next;

    // Payload
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WT_IN_W-1:0] wt_reg;
    logic [STS_W-1:0]   status_reg;
    logic [WT_W-1:0]    prod_reg;
    logic [TOT_W-1:0]   deficit_reg;
    logic [WT_W-1:0]    wsa_rd_reg, wsb_rd_reg;
    logic [AW-1:0]      al_rd_reg, ovs_rd_reg, uns_rd_reg;

    logic [CMPW-1:0] ec_ext;
    logic [CW-1:0]   cnt;
    logic            in_range;
    logic [AW-1:0]   idx_a, ptr_a;
    logic [CW-1:0]   ptr_inc;
    logic            scan_more;
    logic [STS_W-1:0] code;
    logic [PW-1:0]   prod_full;
    logic [WT_W-1:0] mv_new;
    logic            file_en;
    logic [AW-1:0]   file_idx;
    logic [WT_W-1:0] file_val;
    logic            go_over, go_under;

    logic            ws_we;
    logic [AW-1:0]   ws_waddr;
    logic [WT_W-1:0] ws_wdata;
    logic            wsa_re;
    logic [AW-1:0]   wsa_addr;
    logic            al_we;
    logic [AW-1:0]   al_waddr;
    logic [AW-1:0]   al_wdata;

    always_comb begin
        ec_ext    = CMPW'(element_count);
        cnt       = (ec_ext > CMPW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(ec_ext);
        in_range  = CMPW'(idx_reg) < CMPW'(cnt);
        idx_a     = AW'(idx_reg);
        ptr_a     = AW'(ptr_reg);
        ptr_inc   = ptr_reg + CW'(1);
        scan_more = ptr_inc < cnt;
        code      = req_status(op_reg, built_reg, in_range);
        prod_full = PW'(wsa_rd_reg[WT_IN_W-1:0]) * PW'(cnt);
        mv_new    = wsa_rd_reg - WT_W'(deficit_reg);
    end

    assign st.clear_done = (ptr_reg == CW'(MAX_ENTRIES - 1));
    assign st.op         = op_reg;
    assign st.code       = code;
    assign st.cnt_zero   = (cnt == '0);
    assign st.scan_more  = scan_more;
    assign st.can_move   = (oc_reg != '0) && (uc_reg != '0);

    // Filing of an entry onto the overfull or underfull stack
    always_comb begin
        file_en  = cmd.scan_wr || cmd.mv_upd;
        file_idx = cmd.scan_wr ? ptr_a : ovs_rd_reg;
        file_val = cmd.scan_wr ? prod_reg : mv_new;
        go_over  = file_en && (file_val > WT_W'(total_reg)) && (oc_reg < CW'(MAX_ENTRIES));
        go_under = file_en && (file_val < WT_W'(total_reg)) && (uc_reg < CW'(MAX_ENTRIES));
    end

    // Weight store ports
    always_comb begin
        ws_we    = 1'b1;
        ws_waddr = ptr_a;
        ws_wdata = '0;
        if (cmd.set_wr) begin
            ws_waddr = idx_a;
            ws_wdata = WT_W'(wt_reg);
        end else if (cmd.scan_wr) begin
            ws_wdata = prod_reg;
        end else if (cmd.mv_upd) begin
            ws_waddr = ovs_rd_reg;
            ws_wdata = mv_new;
        end else if (!cmd.clr) begin
            ws_we = 1'b0;
        end

        wsa_re   = 1'b1;
        wsa_addr = idx_a;
        if (cmd.scan_rd) begin
            wsa_addr = ptr_a;
        end else if (cmd.scan_wr) begin
            wsa_addr = AW'(ptr_inc);
            wsa_re   = scan_more;
        end else if (cmd.mv_rd) begin
            wsa_addr = ovs_rd_reg;
        end else if (!(cmd.set_rd || cmd.get_rd)) begin
            wsa_re = 1'b0;
        end
    end

    // Alias store write port
    always_comb begin
        al_we    = cmd.clr || cmd.mv_sub;
        al_waddr = cmd.mv_sub ? uns_rd_reg : ptr_a;
        al_wdata = cmd.mv_sub ? ovs_rd_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (ws_we)
            ws_mem[ws_waddr] <= ws_wdata;
        if (wsa_re)
            wsa_rd_reg <= ws_mem[wsa_addr];
        if (cmd.mv_rd)
            wsb_rd_reg <= ws_mem[uns_rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (al_we)
            al_mem[al_waddr] <= al_wdata;
        if (cmd.get_rd)
            al_rd_reg <= al_mem[idx_a];
    end

    always_ff @(posedge aclk) begin
        if (go_over)
            ovs_mem[AW'(oc_reg)] <= file_idx;
        if (cmd.pop)
            ovs_rd_reg <= ovs_mem[AW'(oc_reg - CW'(1))];
    end

    always_ff @(posedge aclk) begin
        if (go_under)
            uns_mem[AW'(uc_reg)] <= file_idx;
        if (cmd.pop)
            uns_rd_reg <= uns_mem[AW'(uc_reg - CW'(1))];
    end

    // Next values of control state
    always_comb begin
        total_next = total_reg;
        built_next = built_reg;
        oc_next    = oc_reg;
        uc_next    = uc_reg;
        ptr_next   = ptr_reg;
        if (cmd.set_wr)
            total_next = total_reg - TOT_W'(wsa_rd_reg) + TOT_W'(wt_reg);
        if (cmd.mark_built)
            built_next = 1'b1;
        if (cmd.scan_init) begin
            oc_next  = '0;
            uc_next  = '0;
            ptr_next = '0;
        end else if (cmd.pop) begin
            oc_next = oc_reg - CW'(1);
            uc_next = uc_reg - CW'(1);
        end else begin
            if (go_over)
                oc_next = oc_reg + CW'(1);
            if (go_under)
                uc_next = uc_reg + CW'(1);
        end
        if (cmd.clr || cmd.scan_wr)
            ptr_next = ptr_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            built_reg <= 1'b0;
            oc_reg    <= '0;
            uc_reg    <= '0;
            ptr_reg   <= '0;
        end else begin
            total_reg <= total_next;
            built_reg <= built_next;
            oc_reg    <= oc_next;
            uc_reg    <= uc_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            op_reg  <= in_op;
            idx_reg <= in_idx;
            wt_reg  <= in_weight;
        end
        if (cmd.judge)
            status_reg <= code;
        if (cmd.scan_mul)
            prod_reg <= WT_W'(prod_full);
        if (cmd.mv_sub)
            deficit_reg <= total_reg - TOT_W'(wsb_rd_reg);
    end

    always_comb begin
        res.status      = status_reg;
        res.threshold   = '0;
        res.alias_index = '0;
        res.total       = total_reg;
        if ((op_reg == OP_GET) && (status_reg == STS_OK)) begin
            res.threshold   = TOT_W'(wsa_rd_reg);
            res.alias_index = IDX_W'(al_rd_reg);
        end
    end

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (oc_reg <= CW'(MAX_ENTRIES)) && (uc_reg <= CW'(MAX_ENTRIES)))
        else $error("stack count beyond depth");

    a_built_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        built_reg |=> built_reg)
        else $error("built flag dropped");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mv_upd |-> (wsa_rd_reg >= WT_W'(deficit_reg)))
        else $error("overfull entry short of deficit");

endmodule

`default_nettype wire

@@ rtl/alias_table_builder_core.sv @@
`default_nettype none

// Alias table builder: builds a Walker/Vose alias table for weighted sampling in exact
// integer arithmetic. Requests come in on the s_ stream (operation in s_tuser: set weight,
// build table, read entry) and each gives exactly one response on the m_ stream (status in
// m_tuser; threshold, alias and running total in m_tdata). Set writes one weight and adjusts
// the total; build scales every active weight by N = min(element_count, MAX_ENTRIES), files
// each entry above or below the total on an overfull or underfull stack and moves mass
// between them until one stack empties, after which the table is read-only. After reset a
// clearing pass writes zero to every weight and alias entry, during which no request is
// taken (APB writes still are). A build scans each of the N entries (read, multiply,
// write) and then makes each mass move in order: pop, the two weight reads, deficit and
// update. One request is worked on at a time; the next is taken while the last response
// waits in the output register. element_count may only be changed while no request is
// outstanding.

module alias_table_builder_core #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [9:0] index, [41:10] weight, [47:42] zero
    input  wire logic [atb_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] operation
    input  wire logic [atb_pkg::OP_W-1:0]          s_tuser,

    // Response stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [41:0] threshold, [51:42] alias_index, [93:52] total, [95:94] zero
    output logic [atb_pkg::M_TDATA_W-1:0]          m_tdata,
    // [1:0] status
    output logic [atb_pkg::STS_W-1:0]              m_tuser,

    // APB register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [atb_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [atb_pkg::APB_DW-1:0]        pwdata,
    output logic [atb_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);
    import atb_pkg::*;

    // Configuration: element_count, word 0
    logic [CFG_W-1:0] elem_count_reg, elem_count_next;
    logic             reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_ELEM_COUNT);
    assign prdata  = reg_hit ? APB_DW'(elem_count_reg) : '0;

    always_comb begin
        elem_count_next = elem_count_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            elem_count_next = pwdata[CFG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            elem_count_reg <= ELEM_COUNT_RST;
        else
            elem_count_reg <= elem_count_next;
    end

    // Controller and datapath
    cmd_t cmd;
    sts_t st;
    res_t res;
    logic out_free;

    // Output register: a response may wait here while the next request is taken
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STS_W-1:0]     m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    atb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd)
    );

    atb_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .element_count (elem_count_reg),
        .in_op         (s_tuser),
        .in_idx        (s_tdata[IDX_W-1:0]),
        .in_weight     (s_tdata[IDX_W+WT_IN_W-1:IDX_W]),
        .res           (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({res.total, res.alias_index, res.threshold});
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
